// ===== design/thread_key_value_table_defines.svh =====
// assertion macros for the thread key value table checker
`ifndef THREAD_KEY_VALUE_TABLE_DEFINES_SVH
`define THREAD_KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TKV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tkv_pkg.sv =====
// types and constants of the thread key value table
package tkv_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int unsigned TAG_W = 16;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned CMD_W = 3;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_OWN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_KEY = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PURGE   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [TAG_W-1:0] thread_tag;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             status;
    logic [VAL_W-1:0] read_value;
    logic [KEY_W-1:0] new_key;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0] thread;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== design/thread_key_value_table.sv =====
// thread key value table: (thread, key) -> value store with a scanned entry memory
//
//   channel   dir   payload                                 handshake
//   in        in    in_item_i  (command, tag, key, value)   in_valid_i / in_ready_o
//   out       out   out_item_o (status, read_value, new_key) out_valid_o / out_ready_i
//
// one item at a time: after accept the scan makes one read per cycle of the entry memory,
// then the drain and finish states follow; finish loads the result into the output
// register, and the next item is taken back in the idle state.
// reset clears the valid bits, key counter and enable flag; no clearing pass.
// a stalled result holds in the output register while the next item is taken
// and scanned; only the finish step waits for the output register to free up.
module thread_key_value_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tkv_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tkv_pkg::out_item_t  out_item_o
);

  tkv_pkg::state_e state_q, state_d;

  logic [tkv_pkg::IDX_W-1:0] cnt_q, cnt_d;
  logic                      cmp_vld_q;
  logic [tkv_pkg::IDX_W-1:0] cmp_idx_q;
  tkv_pkg::entry_t           rd_data_q;

  logic [tkv_pkg::ENTRIES-1:0] valid_q, valid_d;
  logic                        enabled_q, enabled_d;
  logic [tkv_pkg::KEY_W-1:0]   key_ctr_q, key_ctr_d;

  tkv_pkg::in_item_t req_q;

  logic                      found_q, free_found_q;
  logic [tkv_pkg::IDX_W-1:0] hit_idx_q, free_idx_q;
  logic [tkv_pkg::VAL_W-1:0] hit_val_q;

  logic                out_valid_q, out_valid_d;
  tkv_pkg::out_item_t  out_item_q, out_item_d;

  tkv_pkg::entry_t mem [tkv_pkg::ENTRIES];

  logic in_acc, out_free, load, scan_en;
  logic cmp_valid, cmp_hit, do_insert;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tkv_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tkv_pkg::ST_SCAN;
      end
      tkv_pkg::ST_SCAN: begin
        if (cnt_q == tkv_pkg::LAST_IDX) state_d = tkv_pkg::ST_DRAIN;
      end
      tkv_pkg::ST_DRAIN: begin
        state_d = tkv_pkg::ST_FINISH;
      end
      tkv_pkg::ST_FINISH: begin
        if (out_free) state_d = tkv_pkg::ST_IDLE;
      end
      default: begin
        state_d = tkv_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    scan_en    = 1'b0;
    load       = 1'b0;
    case (state_q)
      tkv_pkg::ST_IDLE:   in_ready_o = 1'b1;
      tkv_pkg::ST_SCAN:   scan_en    = 1'b1;
      tkv_pkg::ST_DRAIN:  scan_en    = 1'b0;
      tkv_pkg::ST_FINISH: load       = out_free;
      default:            in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = '0;
    end else if (scan_en) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // compare stage: entry data is registered and arrives in the cycle after its address
  assign cmp_valid = cmp_vld_q && valid_q[cmp_idx_q];
  assign cmp_hit   = cmp_valid && (rd_data_q.thread == req_q.thread_tag)
                     && (rd_data_q.key == req_q.key);

  assign do_insert = (req_q.command == tkv_pkg::CMD_SET) && enabled_q && !found_q
                     && (req_q.value != '0) && free_found_q;

  always_comb begin
    valid_d = valid_q;
    if (cmp_valid) begin
      if (req_q.command == tkv_pkg::CMD_DEL_KEY && rd_data_q.key == req_q.key) begin
        valid_d[cmp_idx_q] = 1'b0;
      end
      if (req_q.command == tkv_pkg::CMD_PURGE && rd_data_q.thread != req_q.thread_tag) begin
        valid_d[cmp_idx_q] = 1'b0;
      end
    end
    if (load) begin
      if (do_insert) valid_d[free_idx_q] = 1'b1;
      if (req_q.command == tkv_pkg::CMD_DEL_OWN && found_q) valid_d[hit_idx_q] = 1'b0;
    end
  end

  always_comb begin
    enabled_d   = enabled_q;
    key_ctr_d   = key_ctr_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      out_item_d  = '0;
      case (req_q.command)
        tkv_pkg::CMD_CREATE: begin
          enabled_d = 1'b1;
          if (key_ctr_q != tkv_pkg::KEY_MAX) key_ctr_d = key_ctr_q + 1'b1;
          out_item_d.new_key = key_ctr_d;
        end
        tkv_pkg::CMD_SET: begin
          out_item_d.status = !(enabled_q && (found_q || do_insert));
        end
        tkv_pkg::CMD_GET: begin
          if (enabled_q && found_q) out_item_d.read_value = hit_val_q;
        end
        default: begin
          out_item_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tkv_pkg::ST_IDLE;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      valid_q      <= '0;
      enabled_q    <= 1'b0;
      key_ctr_q    <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= scan_en;
      valid_q     <= valid_d;
      enabled_q   <= enabled_d;
      key_ctr_q   <= key_ctr_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (cmp_hit) found_q <= 1'b1;
        if (cmp_vld_q && !valid_q[cmp_idx_q]) free_found_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) req_q <= in_item_i;
    cmp_idx_q  <= cnt_q;
    out_item_q <= out_item_d;
    // first hit and lowest free slot win
    if (cmp_hit && !found_q) begin
      hit_idx_q <= cmp_idx_q;
      hit_val_q <= rd_data_q.value;
    end
    if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_found_q) free_idx_q <= cmp_idx_q;
  end

  // entry memory: one read and one write port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (load && do_insert) begin
      mem[free_idx_q] <= '{thread: req_q.thread_tag, key: req_q.key, value: req_q.value};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== design/tkv_checker.sv =====
// port checker for the thread key value table and its bind
`include "thread_key_value_table_defines.svh"

module tkv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input tkv_pkg::out_item_t out_item_i
);

  `TKV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "stalled result item changed")
  `TKV_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "second item taken while one is in work")
  `TKV_ASSERT_NOW(a_fail_clean, clk_i, rst_ni, out_valid_i && out_item_i.status, out_item_i.read_value == '0 && out_item_i.new_key == '0, "failed set carries data")
  `TKV_ASSERT_NOW(a_create_clean, clk_i, rst_ni, out_valid_i && out_item_i.new_key != '0, out_item_i.read_value == '0 && !out_item_i.status, "create result mixes fields")

endmodule

bind thread_key_value_table tkv_checker u_tkv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);
